FILE: src/dqir_pkg.sv
// Shared types, codes and ring arithmetic for the deque with indexed remove.
// No dependencies; imported by the top level.
package dqir_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 64;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W      = SLOT_W + 1;
  localparam int IDX_W      = 9;
  localparam int CMP_W      = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

  // Port field widths.
  localparam int VAL_W      = 64;
  localparam int OPC_W      = 3;
  localparam int STAT_W     = 2;
  localparam int CNT_OUT_W  = 9;
  localparam int TDATA_W    = 80;

  localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPC_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPC_W-1:0] OP_GET        = 3'd4;
  localparam logic [OPC_W-1:0] OP_REMOVE     = 3'd5;
  localparam logic [OPC_W-1:0] OP_REVERSE    = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Ring slot of logical position pos, walking up or down from first.
  function automatic slot_t slot_of(input slot_t first, input logic rev, input count_t pos);
    count_t           p;
    logic [SUM_W-1:0] s;
    p = (pos >= COUNT_W'(CAPACITY)) ? pos - COUNT_W'(CAPACITY) : pos;
    if (rev) begin
      s = SUM_W'(first) + SUM_W'(CAPACITY) - SUM_W'(p);
    end else begin
      s = SUM_W'(first) + SUM_W'(p);
    end
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return SLOT_W'(s);
  endfunction

endpackage

FILE: src/dqir_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dqir_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/deque_with_indexed_remove_unit.sv
// Bounded double-ended queue of words held in a ring of CAPACITY slots, with
// reverse in constant time through a direction flag. Depends on dqir_pkg, dqir_ram.
//
// Every input transaction yields exactly one output transaction carrying the
// word read (zero unless pop or get), a status and the entry count after the
// operation. Pushes, reverse, unused opcodes and any failed operation load
// their result on acceptance; pop and get load it from S_READ, after the
// registered read of the entry RAM. Remove of entry k from n entries closes
// the gap in S_SHIFT by moving each of the n - k later entries one place toward
// the front, one RAM read and one RAM write per cycle. The RAM needs no clearing
// after reset; only held entries are ever read.
module deque_with_indexed_remove_unit
  import dqir_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [63:0] value, [72:64] index, [79:73] zero
  input  logic [OPC_W-1:0]   s_tuser,   // [2:0] opcode
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [63:0] value_out, [72:64] count, [79:73] zero
  output logic [STAT_W-1:0]  m_tuser    // [1:0] status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0] state, state_next;
  slot_t      first_slot, first_slot_next;
  count_t     entry_count, entry_count_next;
  logic       reversed, reversed_next;
  count_t     wr_pos, wr_pos_next;
  count_t     shift_left, shift_left_next;

  logic                  we, re;
  slot_t                 waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  logic                  out_load;
  logic [VAL_W-1:0]      out_val;
  logic [STAT_W-1:0]     out_status;

  logic                  accept;
  logic [OPC_W-1:0]      in_op;
  logic [IDX_W-1:0]      in_idx;
  logic                  is_empty, is_full, idx_ok, idx_last;
  count_t                idx_pos;

  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign in_op    = s_tuser;
  assign in_idx   = s_tdata[VAL_W +: IDX_W];
  assign is_empty = (entry_count == '0);
  assign is_full  = (entry_count >= COUNT_W'(CAPACITY));
  assign idx_ok   = (in_idx != '0) && (CMP_W'(in_idx) <= CMP_W'(entry_count));
  assign idx_last = (CMP_W'(in_idx) == CMP_W'(entry_count));
  assign idx_pos  = COUNT_W'(in_idx);

  always_comb begin
    state_next       = state;
    first_slot_next  = first_slot;
    entry_count_next = entry_count;
    reversed_next    = reversed;
    wr_pos_next      = wr_pos;
    shift_left_next  = shift_left;
    we               = 1'b0;
    waddr            = first_slot;
    wdata            = s_tdata[DATA_WIDTH-1:0];
    re               = 1'b0;
    raddr            = first_slot;
    out_load         = 1'b0;
    out_val          = '0;
    out_status       = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          case (in_op)
            OP_PUSH_BACK: begin
              if (is_full) begin
                out_status = ST_FULL;
              end else begin
                we               = 1'b1;
                waddr            = slot_of(first_slot, reversed, entry_count);
                entry_count_next = entry_count + 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (is_full) begin
                out_status = ST_FULL;
              end else begin
                we               = 1'b1;
                waddr            = slot_of(first_slot, !reversed, COUNT_W'(1));
                first_slot_next  = waddr;
                entry_count_next = entry_count + 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                out_status = ST_EMPTY;
              end else begin
                re               = 1'b1;
                raddr            = slot_of(first_slot, reversed, entry_count - 1'b1);
                entry_count_next = entry_count - 1'b1;
                out_load         = 1'b0;
                state_next       = S_READ;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                out_status = ST_EMPTY;
              end else begin
                re               = 1'b1;
                raddr            = first_slot;
                first_slot_next  = slot_of(first_slot, reversed, COUNT_W'(1));
                entry_count_next = entry_count - 1'b1;
                out_load         = 1'b0;
                state_next       = S_READ;
              end
            end
            OP_GET: begin
              if (is_empty) begin
                out_status = ST_EMPTY;
              end else if (!idx_ok) begin
                out_status = ST_RANGE;
              end else begin
                re         = 1'b1;
                raddr      = slot_of(first_slot, reversed, idx_pos - 1'b1);
                out_load   = 1'b0;
                state_next = S_READ;
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                out_status = ST_EMPTY;
              end else if (!idx_ok) begin
                out_status = ST_RANGE;
              end else begin
                entry_count_next = entry_count - 1'b1;
                if (!idx_last) begin
                  re              = 1'b1;
                  raddr           = slot_of(first_slot, reversed, idx_pos);
                  wr_pos_next     = idx_pos - 1'b1;
                  shift_left_next = entry_count - idx_pos;
                  out_load        = 1'b0;
                  state_next      = S_SHIFT;
                end
              end
            end
            OP_REVERSE: begin
              if (entry_count >= COUNT_W'(2)) begin
                first_slot_next = slot_of(first_slot, reversed, entry_count - 1'b1);
                reversed_next   = !reversed;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_load   = 1'b1;
        out_val    = VAL_W'(rdata);
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        we              = 1'b1;
        waddr           = slot_of(first_slot, reversed, wr_pos);
        wdata           = rdata;
        wr_pos_next     = wr_pos + 1'b1;
        shift_left_next = shift_left - 1'b1;
        if (shift_left > COUNT_W'(1)) begin
          re    = 1'b1;
          raddr = slot_of(first_slot, reversed, wr_pos + COUNT_W'(2));
        end else begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      first_slot  <= '0;
      entry_count <= '0;
      reversed    <= 1'b0;
      wr_pos      <= '0;
      shift_left  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      first_slot  <= first_slot_next;
      entry_count <= entry_count_next;
      reversed    <= reversed_next;
      wr_pos      <= wr_pos_next;
      shift_left  <= shift_left_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(TDATA_W - VAL_W - CNT_OUT_W)'(0), CNT_OUT_W'(entry_count_next), out_val};
      m_tuser <= out_status;
    end
  end

  dqir_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_SHIFT) |-> !m_tvalid)
    else $error("result pending while an operation is in flight");

  a_read_completes: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (m_tvalid && state == S_IDLE))
    else $error("pop or get did not deliver its result");

  a_reverse_needs_two: assert property (@(posedge clk) disable iff (rst)
    (reversed != $past(reversed)) |-> ($past(entry_count) >= COUNT_W'(2)))
    else $error("direction flipped on a short queue");

  a_shift_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && shift_left > COUNT_W'(1)) |=>
      (state == S_SHIFT && shift_left == $past(shift_left) - 1'b1))
    else $error("remove shift stalled");

endmodule

FILE: bench/tb_deque_with_indexed_remove_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for deque_with_indexed_remove_unit: a directed table, a fill to capacity,
// then biased random traffic; typed table rows are scored against their listed results, the
// rest against an in-bench deque predictor. Depends on dqir_pkg and the unit under test.
module tb_deque_with_indexed_remove_unit;
  import dqir_pkg::*;

  localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [63:0]        val;
    logic [STAT_W-1:0]  st;
    logic [8:0]         cnt;
  } deq_result_t;

  typedef struct packed {
    logic [OPC_W-1:0]   op;
    logic [63:0]        v;
    logic [8:0]         ix;
    logic               typed;
    logic [63:0]        ev;
    logic [STAT_W-1:0]  es;
    logic [8:0]         ec;
  } deq_row_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;   // [63:0] value, [72:64] index, [79:73] zero
  logic [OPC_W-1:0]   s_tuser;   // [2:0] opcode
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;   // [63:0] value_out, [72:64] count, [79:73] zero
  logic [STAT_W-1:0]  m_tuser;   // [1:0] status

  deque_with_indexed_remove_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predictor state
  logic [DATA_WIDTH-1:0] ring_words [CAPACITY];
  int                    ring_first = 0;
  int                    ring_count = 0;
  logic                  ring_rev = 1'b0;

  deq_result_t due_results [$];
  deq_result_t pred;
  deq_result_t want;
  logic        drv_typed = 1'b0;
  deq_result_t drv_want = '0;

  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_removes = 0;
  int peak_count = 0;
  int status_hits [4] = '{0, 0, 0, 0};

  deq_row_t dir_rows [26];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int ring_slot(int pos);
    int p;
    p = pos % CAPACITY;
    if (ring_rev) return (ring_first + CAPACITY - p) % CAPACITY;
    return (ring_first + p) % CAPACITY;
  endfunction

  task automatic apply_deque_op(input logic [OPC_W-1:0] op, input logic [63:0] v,
                                input logic [8:0] ix_in, output deq_result_t r);
    int ix;
    int i;
    logic [63:0] rd;
    logic [STAT_W-1:0] st;
    ix = int'(ix_in);
    rd = '0;
    st = ST_OK;
    case (op)
      OP_PUSH_BACK: begin
        if (ring_count >= CAPACITY) st = ST_FULL;
        else begin
          ring_words[ring_slot(ring_count)] = v;
          ring_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (ring_count >= CAPACITY) st = ST_FULL;
        else begin
          ring_first = ring_rev ? (ring_first + 1) % CAPACITY
                                : (ring_first + CAPACITY - 1) % CAPACITY;
          ring_words[ring_first] = v;
          ring_count++;
        end
      end
      OP_POP_BACK: begin
        if (ring_count == 0) st = ST_EMPTY;
        else begin
          rd = ring_words[ring_slot(ring_count - 1)];
          ring_count--;
        end
      end
      OP_POP_FRONT: begin
        if (ring_count == 0) st = ST_EMPTY;
        else begin
          rd = ring_words[ring_first];
          ring_first = ring_slot(1);
          ring_count--;
        end
      end
      OP_GET: begin
        if (ring_count == 0) st = ST_EMPTY;
        else if (ix == 0 || ix > ring_count) st = ST_RANGE;
        else rd = ring_words[ring_slot(ix - 1)];
      end
      OP_REMOVE: begin
        if (ring_count == 0) st = ST_EMPTY;
        else if (ix == 0 || ix > ring_count) st = ST_RANGE;
        else begin
          for (i = ix - 1; i + 1 < ring_count; i++)
            ring_words[ring_slot(i)] = ring_words[ring_slot(i + 1)];
          ring_count--;
        end
      end
      OP_REVERSE: begin
        if (ring_count >= 2) begin
          ring_first = ring_slot(ring_count - 1);
          ring_rev = ~ring_rev;
        end
      end
      default: begin
      end
    endcase
    r.val = rd;
    r.st  = st;
    r.cnt = 9'(ring_count);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("[%0t] MISMATCH %s (result %0d): got 0x%0h, want 0x%0h",
             $realtime, field, n_out, got, exp_val);
    errors++;
  endtask

  // scoreboard: predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        apply_deque_op(s_tuser, s_tdata[63:0], s_tdata[72:64], pred);
        if (drv_typed) pred = drv_want;
        due_results.push_back(pred);
        n_in++;
        status_hits[pred.st]++;
        if (s_tuser == OP_REMOVE && pred.st == ST_OK) n_removes++;
        if (ring_count > peak_count) peak_count = ring_count;
      end
      if (m_tvalid && m_tready) begin
        n_out++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[63:0], '0);
        end else begin
          want = due_results.pop_front();
          if (m_tdata[63:0] !== want.val) report_mismatch("value_out", m_tdata[63:0], want.val);
          if (m_tuser !== want.st) report_mismatch("status", 64'(m_tuser), 64'(want.st));
          if (m_tdata[72:64] !== want.cnt)
            report_mismatch("count", 64'(m_tdata[72:64]), 64'(want.cnt));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic deq_row_t mk_row(logic [OPC_W-1:0] op, logic [63:0] v, logic [8:0] ix,
                                      logic typed, logic [63:0] ev, logic [STAT_W-1:0] es,
                                      logic [8:0] ec);
    deq_row_t t;
    t.op = op;
    t.v = v;
    t.ix = ix;
    t.typed = typed;
    t.ev = ev;
    t.es = es;
    t.ec = ec;
    return t;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [63:0] v,
                           input logic [8:0] ix, input logic typed, input deq_result_t exp_r);
    drv_typed = typed;
    drv_want = exp_r;
    s_tdata = {7'd0, ix, v};
    s_tuser = op;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_tvalid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  // receiver: random backpressure plus one long hold on request
  initial begin
    int hold_left;
    int g;
    m_tready = 1'b0;
    hold_left = 0;
    g = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (g > 0) begin
        m_tready = 1'b0;
        g--;
      end else begin
        m_tready = 1'b1;
        g = pick_gap();
      end
    end
  end

  initial begin
    int k;
    int r;
    logic fill;
    logic [OPC_W-1:0] op;
    logic [63:0] v;
    logic [8:0] ix;
    deq_result_t none;
    deq_result_t tw;
    none = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    rst = 1'b1;
    dir_rows[0]  = mk_row(OP_POP_BACK,   '0, 9'd0,   1'b1, '0, ST_EMPTY, 9'd0);
    dir_rows[1]  = mk_row(OP_POP_FRONT,  '0, 9'd0,   1'b1, '0, ST_EMPTY, 9'd0);
    dir_rows[2]  = mk_row(OP_GET,        '0, 9'd1,   1'b1, '0, ST_EMPTY, 9'd0);
    dir_rows[3]  = mk_row(OP_REMOVE,     '0, 9'd0,   1'b1, '0, ST_EMPTY, 9'd0);
    dir_rows[4]  = mk_row(OP_REVERSE,    '0, 9'd0,   1'b1, '0, ST_OK,    9'd0);
    dir_rows[5]  = mk_row(OP_UNUSED,     '1, 9'd256, 1'b1, '0, ST_OK,    9'd0);
    dir_rows[6]  = mk_row(OP_PUSH_BACK,  '1, 9'd0,   1'b1, '0, ST_OK,    9'd1);
    dir_rows[7]  = mk_row(OP_REVERSE,    '0, 9'd0,   1'b1, '0, ST_OK,    9'd1);
    dir_rows[8]  = mk_row(OP_GET,        '0, 9'd1,   1'b1, '1, ST_OK,    9'd1);
    dir_rows[9]  = mk_row(OP_PUSH_FRONT, '0, 9'd0,   1'b1, '0, ST_OK,    9'd2);
    dir_rows[10] = mk_row(OP_PUSH_BACK,  64'h8000_0000_0000_0001, 9'd0, 1'b1, '0, ST_OK, 9'd3);
    dir_rows[11] = mk_row(OP_GET,        '0, 9'd0,   1'b1, '0, ST_RANGE, 9'd3);
    dir_rows[12] = mk_row(OP_GET,        '0, 9'd4,   1'b1, '0, ST_RANGE, 9'd3);
    dir_rows[13] = mk_row(OP_GET,        '0, 9'd256, 1'b1, '0, ST_RANGE, 9'd3);
    dir_rows[14] = mk_row(OP_REMOVE,     '0, 9'd256, 1'b1, '0, ST_RANGE, 9'd3);
    dir_rows[15] = mk_row(OP_GET,        '0, 9'd1,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[16] = mk_row(OP_REVERSE,    '0, 9'd0,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[17] = mk_row(OP_GET,        '0, 9'd3,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[18] = mk_row(OP_REMOVE,     '0, 9'd2,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[19] = mk_row(OP_POP_FRONT,  '0, 9'd0,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[20] = mk_row(OP_PUSH_FRONT, 64'h5555_5555_5555_5555, 9'd0, 1'b0, '0, ST_OK, 9'd0);
    dir_rows[21] = mk_row(OP_POP_BACK,   '0, 9'd0,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[22] = mk_row(OP_REMOVE,     '0, 9'd1,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[23] = mk_row(OP_PUSH_BACK,  64'hAAAA_AAAA_AAAA_AAAA, 9'd0, 1'b0, '0, ST_OK, 9'd0);
    dir_rows[24] = mk_row(OP_POP_FRONT,  '0, 9'd0,   1'b0, '0, ST_OK, 9'd0);
    dir_rows[25] = mk_row(OP_UNUSED,     64'h1234_5678_9ABC_DEF0, 9'd17, 1'b1, '0, ST_OK, 9'd0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (k = 0; k < 26; k++) begin
      tw.val = dir_rows[k].ev;
      tw.st = dir_rows[k].es;
      tw.cnt = dir_rows[k].ec;
      send_item(dir_rows[k].op, dir_rows[k].v, dir_rows[k].ix, dir_rows[k].typed, tw);
      sender_gap();
    end

    // fill to capacity, then exercise the full-queue corners
    while (ring_count < CAPACITY) begin
      op = ($urandom_range(0, 1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      send_item(op, {$urandom, $urandom}, 9'(ring_count), 1'b0, none);
      sender_gap();
    end
    send_item(OP_PUSH_BACK,  '1, 9'd0,   1'b0, none); sender_gap();
    send_item(OP_PUSH_FRONT, '1, 9'd0,   1'b0, none); sender_gap();
    send_item(OP_GET,        '0, 9'd256, 1'b0, none); sender_gap();
    send_item(OP_REVERSE,    '0, 9'd0,   1'b0, none); sender_gap();
    send_item(OP_GET,        '0, 9'd1,   1'b0, none); sender_gap();
    send_item(OP_REMOVE,     '0, 9'd256, 1'b0, none); sender_gap();
    send_item(OP_PUSH_FRONT, {$urandom, $urandom}, 9'd0, 1'b0, none); sender_gap();
    send_item(OP_REMOVE,     '0, 9'd1,   1'b0, none); sender_gap();
    send_item(OP_PUSH_BACK,  {$urandom, $urandom}, 9'd0, 1'b0, none); sender_gap();
    send_item(OP_POP_BACK,   '0, 9'd0,   1'b0, none);
    drain_results();

    // random traffic in alternating drain and fill phases
    for (k = 0; k < 1170; k++) begin
      if (k == 300) begin
        hold_req = 1'b1;
        no_idle = 1'b1;
      end
      if (k == 360) no_idle = 1'b0;
      if (k == 700) drain_results();
      if (k == 900) no_idle = 1'b1;
      if (k == 1100) no_idle = 1'b0;

      fill = ((k / 300) % 2) == 1;
      r = $urandom_range(0, 99);
      if (fill) begin
        if (r < 35) op = OP_PUSH_BACK;
        else if (r < 70) op = OP_PUSH_FRONT;
        else if (r < 75) op = OP_POP_BACK;
        else if (r < 80) op = OP_POP_FRONT;
        else if (r < 88) op = OP_GET;
        else if (r < 93) op = OP_REMOVE;
        else if (r < 98) op = OP_REVERSE;
        else op = OP_UNUSED;
      end else begin
        if (r < 5) op = OP_PUSH_BACK;
        else if (r < 10) op = OP_PUSH_FRONT;
        else if (r < 38) op = OP_POP_BACK;
        else if (r < 65) op = OP_POP_FRONT;
        else if (r < 80) op = OP_GET;
        else if (r < 93) op = OP_REMOVE;
        else if (r < 98) op = OP_REVERSE;
        else op = OP_UNUSED;
      end

      r = $urandom_range(0, 19);
      if (r == 0) v = '0;
      else if (r == 1) v = '1;
      else v = {$urandom, $urandom};

      if (ring_count > 0 && $urandom_range(0, 99) < 85) begin
        ix = 9'($urandom_range(1, ring_count));
      end else begin
        case ($urandom_range(0, 2))
          0: ix = 9'd0;
          1: ix = (ring_count < CAPACITY) ? 9'(ring_count + 1) : 9'd256;
          default: ix = 9'($urandom_range(0, 256));
        endcase
      end

      send_item(op, v, ix, 1'b0, none);
      sender_gap();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (due_results.size() != 0)
      report_mismatch("leftover expectations", 64'(due_results.size()), '0);

    $display("Summary: %0d transactions in, %0d out; ok/empty/range/full = %0d/%0d/%0d/%0d",
             n_in, n_out, status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    $display("Summary: peak depth %0d, %0d removes, long output hold and sender drains included",
             peak_count, n_removes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TIMEOUT after %0d results", n_out);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
src/dqir_pkg.sv
src/dqir_ram.sv
src/deque_with_indexed_remove_unit.sv
bench/tb_deque_with_indexed_remove_unit.sv
